FILE: sv/hsvrgb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// HSV to RGB package
// Widths, constants and pipeline control types shared by the converter.
// ----------------------------------------------------------------------------
package hsvrgb_pkg;

  localparam int unsigned HueW    = 9;
  localparam int unsigned ChanW   = 8;
  localparam int unsigned SectorW = 4;   // sectors 0..8 for hue 0..511
  localparam int unsigned RemW    = 6;   // remainder 0..59
  localparam int unsigned PnumW   = 16;  // V * (255 - S)
  localparam int unsigned LevelW  = 14;  // 15300 - S * x, below 2**14
  localparam int unsigned NumW    = 22;  // V * level, at most 255 * 15300
  localparam int unsigned RecipW  = 23;
  localparam int unsigned ProdW   = NumW + RecipW;

  localparam int unsigned SectorDeg = 60;
  localparam int unsigned NumSectorCmp = 8;

  localparam logic [ChanW-1:0]  FullScale = 8'd255;
  localparam logic [RemW-1:0]   SectorSpan = 6'd60;
  localparam logic [LevelW-1:0] Denom = 14'd15300;   // 255 * 60

  // floor(x / 15300) == (x * RecipM) >> RecipShift for every x below 2**22:
  // RecipM * 15300 - 2**36 = 14264, which stays below 2**(36 - 22).
  localparam logic [RecipW-1:0] RecipM = 23'd4491470;
  localparam int unsigned RecipShift = 36;

  // Sector codes that pick the channel routing.
  localparam logic [SectorW-1:0] SecRedYel   = 4'd0;
  localparam logic [SectorW-1:0] SecYelGrn   = 4'd1;
  localparam logic [SectorW-1:0] SecGrnCyan  = 4'd2;
  localparam logic [SectorW-1:0] SecCyanBlu  = 4'd3;
  localparam logic [SectorW-1:0] SecBluMag   = 4'd4;

  // Load enables, one per pipeline stage.
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } pipe_ld_t;

endpackage
`default_nettype wire

FILE: sv/hsvrgb_sector.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// HSV to RGB sector stage
// First stage: splits hue into sector and remainder and forms V * (255 - S).
// ----------------------------------------------------------------------------
module hsvrgb_sector
  import hsvrgb_pkg::*;
(
  input  wire logic               clk_i,
  input  wire pipe_ld_t           ld_i,
  input  wire logic [HueW-1:0]    hue_i,
  input  wire logic [ChanW-1:0]   sat_i,
  input  wire logic [ChanW-1:0]   val_i,
  output logic      [SectorW-1:0] sector_o,
  output logic      [RemW-1:0]    rem_o,
  output logic      [ChanW-1:0]   sat_o,
  output logic      [ChanW-1:0]   val_o,
  output logic      [PnumW-1:0]   pnum_o
);

  logic [SectorW-1:0] sector_d, sector_q;
  logic [RemW-1:0]    rem_d, rem_q;
  logic [HueW-1:0]    base;
  logic [PnumW-1:0]   pnum_d, pnum_q;
  logic [ChanW-1:0]   sat_q, val_q;

  // The sector is the number of sector boundaries at or below the hue.
  always_comb begin
    sector_d = '0;
    for (int k = 1; k <= NumSectorCmp; k++) begin
      if (hue_i >= HueW'(k * SectorDeg)) begin
        sector_d = sector_d + SectorW'(1);
      end
    end
    base   = HueW'(sector_d) * HueW'(SectorDeg);
    rem_d  = RemW'(hue_i - base);
    pnum_d = PnumW'(val_i) * PnumW'(FullScale - sat_i);
  end

  always_ff @(posedge clk_i) begin
    if (ld_i.s1) begin
      sector_q <= sector_d;
      rem_q    <= rem_d;
      sat_q    <= sat_i;
      val_q    <= val_i;
      pnum_q   <= pnum_d;
    end
  end

  assign sector_o = sector_q;
  assign rem_o    = rem_q;
  assign sat_o    = sat_q;
  assign val_o    = val_q;
  assign pnum_o   = pnum_q;

endmodule
`default_nettype wire

FILE: sv/hsvrgb_levels.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// HSV to RGB level stages
// Stages two to four: form the levels p, q and t with exact floor division.
// ----------------------------------------------------------------------------
module hsvrgb_levels
  import hsvrgb_pkg::*;
(
  input  wire logic               clk_i,
  input  wire pipe_ld_t           ld_i,
  input  wire logic [SectorW-1:0] sector_i,
  input  wire logic [RemW-1:0]    rem_i,
  input  wire logic [ChanW-1:0]   sat_i,
  input  wire logic [ChanW-1:0]   val_i,
  input  wire logic [PnumW-1:0]   pnum_i,
  output logic      [SectorW-1:0] sector_o,
  output logic      [ChanW-1:0]   val_o,
  output logic      [ChanW-1:0]   p_o,
  output logic      [ChanW-1:0]   q_o,
  output logic      [ChanW-1:0]   t_o
);

  // Stage 2: level factors and p.
  logic [SectorW-1:0] sector2_q, sector3_q, sector4_q;
  logic [ChanW-1:0]   val2_q, val3_q, val4_q;
  logic [ChanW-1:0]   p2_d, p2_q, p3_q, p4_q;
  logic [LevelW-1:0]  qd2_d, qd2_q, td2_d, td2_q;
  logic [PnumW:0]     pdiv;
  logic [NumW-1:0]    qn3_d, qn3_q, tn3_d, tn3_q;
  logic [ProdW-1:0]   qprod, tprod;
  logic [ChanW-1:0]   q4_d, q4_q, t4_d, t4_q;

  always_comb begin
    // x / 255, rounded down, for x up to 255 * 255 is (x + (x >> 8) + 1) >> 8.
    pdiv  = (PnumW+1)'(pnum_i) + (PnumW+1)'(pnum_i[PnumW-1:ChanW]) + (PnumW+1)'(1);
    p2_d  = pdiv[PnumW-1:ChanW];
    qd2_d = Denom - LevelW'(LevelW'(sat_i) * LevelW'(rem_i));
    td2_d = Denom - LevelW'(LevelW'(sat_i) * LevelW'(SectorSpan - rem_i));
  end

  always_ff @(posedge clk_i) begin
    if (ld_i.s2) begin
      sector2_q <= sector_i;
      val2_q    <= val_i;
      p2_q      <= p2_d;
      qd2_q     <= qd2_d;
      td2_q     <= td2_d;
    end
  end

  // Stage 3: numerators.
  assign qn3_d = NumW'(val2_q) * NumW'(qd2_q);
  assign tn3_d = NumW'(val2_q) * NumW'(td2_q);

  always_ff @(posedge clk_i) begin
    if (ld_i.s3) begin
      sector3_q <= sector2_q;
      val3_q    <= val2_q;
      p3_q      <= p2_q;
      qn3_q     <= qn3_d;
      tn3_q     <= tn3_d;
    end
  end

  // Stage 4: division by 15300 through the reciprocal.
  always_comb begin
    qprod = ProdW'(qn3_q) * ProdW'(RecipM);
    tprod = ProdW'(tn3_q) * ProdW'(RecipM);
    q4_d  = qprod[RecipShift +: ChanW];
    t4_d  = tprod[RecipShift +: ChanW];
  end

  always_ff @(posedge clk_i) begin
    if (ld_i.s4) begin
      sector4_q <= sector3_q;
      val4_q    <= val3_q;
      p4_q      <= p3_q;
      q4_q      <= q4_d;
      t4_q      <= t4_d;
    end
  end

  assign sector_o = sector4_q;
  assign val_o    = val4_q;
  assign p_o      = p4_q;
  assign q_o      = q4_q;
  assign t_o      = t4_q;

endmodule
`default_nettype wire

FILE: sv/hsvrgb_select.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// HSV to RGB channel select
// Last stage: routes V, p, q and t to the channels by sector into the output.
// ----------------------------------------------------------------------------
module hsvrgb_select
  import hsvrgb_pkg::*;
(
  input  wire logic               clk_i,
  input  wire pipe_ld_t           ld_i,
  input  wire logic [SectorW-1:0] sector_i,
  input  wire logic [ChanW-1:0]   val_i,
  input  wire logic [ChanW-1:0]   p_i,
  input  wire logic [ChanW-1:0]   q_i,
  input  wire logic [ChanW-1:0]   t_i,
  output logic      [ChanW-1:0]   red_o,
  output logic      [ChanW-1:0]   green_o,
  output logic      [ChanW-1:0]   blue_o
);

  logic [ChanW-1:0] red_d, green_d, blue_d;
  logic [ChanW-1:0] red_q, green_q, blue_q;

  // Hues past 359 fall into the last sector's routing.
  always_comb begin
    case (sector_i)
      SecRedYel: begin
        red_d = val_i; green_d = t_i;   blue_d = p_i;
      end
      SecYelGrn: begin
        red_d = q_i;   green_d = val_i; blue_d = p_i;
      end
      SecGrnCyan: begin
        red_d = p_i;   green_d = val_i; blue_d = t_i;
      end
      SecCyanBlu: begin
        red_d = p_i;   green_d = q_i;   blue_d = val_i;
      end
      SecBluMag: begin
        red_d = t_i;   green_d = p_i;   blue_d = val_i;
      end
      default: begin
        red_d = val_i; green_d = p_i;   blue_d = q_i;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ld_i.s5) begin
      red_q   <= red_d;
      green_q <= green_d;
      blue_q  <= blue_d;
    end
  end

  assign red_o   = red_q;
  assign green_o = green_q;
  assign blue_o  = blue_q;

endmodule
`default_nettype wire

FILE: sv/hsv_to_rgb_converter.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// HSV to RGB converter, 8 bits per channel
// Five-stage pipeline turning hue, saturation and value into red, green, blue.
// ----------------------------------------------------------------------------
// The converter takes one word per clock and returns one word per clock while
// the output side is ready. The five register stages are: sector split of the
// hue and V * (255 - S); the p level and the two level factors 15300 - S * r
// and 15300 - S * (60 - r); the q and t numerators; exact division by 15300
// through a reciprocal multiply; and the channel routing into the output
// register. Each stage has a valid bit and loads whenever it is empty or the
// stage after it moves, so back pressure on the output side fills the bubbles
// first and then holds every stage without dropping or repeating a word. Zero
// saturation needs no special path: all three levels then equal V. Hues from
// 360 to 511 take the routing of the last sector, with the remainder still hue
// modulo 60.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter
  import hsvrgb_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // [8:0] hue, [16:9] saturation, [24:17] brightness, [31:25] zero
  input  wire logic [31:0] s_axis_tdata_i,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // [7:0] red, [15:8] green, [23:16] blue
  output logic      [23:0] m_axis_tdata_o
);

  pipe_ld_t         ld;
  logic [4:0]       vld_d, vld_q;   // valid bit of stage 1 in bit 0
  logic [SectorW-1:0] s1_sector, s4_sector;
  logic [RemW-1:0]  s1_rem;
  logic [ChanW-1:0] s1_sat, s1_val, s4_val, s4_p, s4_q, s4_t;
  logic [PnumW-1:0] s1_pnum;
  logic [ChanW-1:0] red, green, blue;

  // A stage may load when it is empty or its contents move on this cycle.
  always_comb begin
    ld.s5 = !vld_q[4] || m_axis_tready_i;
    ld.s4 = !vld_q[3] || ld.s5;
    ld.s3 = !vld_q[2] || ld.s4;
    ld.s2 = !vld_q[1] || ld.s3;
    ld.s1 = !vld_q[0] || ld.s2;
  end

  always_comb begin
    vld_d = vld_q;
    if (ld.s1) begin
      vld_d[0] = s_axis_tvalid_i;
    end
    if (ld.s2) begin
      vld_d[1] = vld_q[0];
    end
    if (ld.s3) begin
      vld_d[2] = vld_q[1];
    end
    if (ld.s4) begin
      vld_d[3] = vld_q[2];
    end
    if (ld.s5) begin
      vld_d[4] = vld_q[3];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  hsvrgb_sector u_sector (
    .clk_i    (clk_i),
    .ld_i     (ld),
    .hue_i    (s_axis_tdata_i[8:0]),
    .sat_i    (s_axis_tdata_i[16:9]),
    .val_i    (s_axis_tdata_i[24:17]),
    .sector_o (s1_sector),
    .rem_o    (s1_rem),
    .sat_o    (s1_sat),
    .val_o    (s1_val),
    .pnum_o   (s1_pnum)
  );

  hsvrgb_levels u_levels (
    .clk_i    (clk_i),
    .ld_i     (ld),
    .sector_i (s1_sector),
    .rem_i    (s1_rem),
    .sat_i    (s1_sat),
    .val_i    (s1_val),
    .pnum_i   (s1_pnum),
    .sector_o (s4_sector),
    .val_o    (s4_val),
    .p_o      (s4_p),
    .q_o      (s4_q),
    .t_o      (s4_t)
  );

  hsvrgb_select u_select (
    .clk_i    (clk_i),
    .ld_i     (ld),
    .sector_i (s4_sector),
    .val_i    (s4_val),
    .p_i      (s4_p),
    .q_i      (s4_q),
    .t_i      (s4_t),
    .red_o    (red),
    .green_o  (green),
    .blue_o   (blue)
  );

  assign s_axis_tready_o = ld.s1;
  assign m_axis_tvalid_o = vld_q[4];
  assign m_axis_tdata_o  = {blue, green, red};

endmodule
`default_nettype wire

FILE: sv/hsvrgb_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// HSV to RGB port checker
// Checks latency, grey and pure red results and output hold on the ports.
// ----------------------------------------------------------------------------
module hsvrgb_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid_i,
  input wire logic        s_axis_tready_o,
  input wire logic [31:0] s_axis_tdata_i,
  input wire logic        m_axis_tvalid_o,
  input wire logic        m_axis_tready_i,
  input wire logic [23:0] m_axis_tdata_o
);

  logic       in_acc;
  logic       flow;
  logic       clean;
  logic [4:0] acc_hist_q;
  logic [3:0] flow_hist_q;

  assign in_acc = s_axis_tvalid_i && s_axis_tready_o && rst_ni;
  assign flow   = m_axis_tready_i && rst_ni;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_hist_q  <= '0;
      flow_hist_q <= '0;
    end else begin
      acc_hist_q  <= {acc_hist_q[3:0], in_acc};
      flow_hist_q <= {flow_hist_q[2:0], flow};
    end
  end

  // A word taken in the oldest acc_hist_q slot, output ready since then.
  assign clean = acc_hist_q[4] && (&flow_hist_q) && rst_ni;

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clean |-> m_axis_tvalid_o)
    else $error("word not delivered after five cycles without stall");

  a_grey: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (clean && $past(s_axis_tdata_i[16:9], 5) == 8'd0) |->
      (m_axis_tdata_o[7:0] == $past(s_axis_tdata_i[24:17], 5) &&
       m_axis_tdata_o[15:8] == $past(s_axis_tdata_i[24:17], 5) &&
       m_axis_tdata_o[23:16] == $past(s_axis_tdata_i[24:17], 5)))
    else $error("zero saturation did not give grey");

  a_pure_red: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (clean && $past(s_axis_tdata_i[8:0], 5) == 9'd0 &&
     $past(s_axis_tdata_i[16:9], 5) == 8'd255) |->
      (m_axis_tdata_o[7:0] == $past(s_axis_tdata_i[24:17], 5) &&
       m_axis_tdata_o[23:8] == 16'd0))
    else $error("hue zero at full saturation did not give pure red");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=>
      (m_axis_tvalid_o && $stable(m_axis_tdata_o)))
    else $error("stalled output word changed");

endmodule

bind hsv_to_rgb_converter hsvrgb_checker u_hsvrgb_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tdata_i  (s_axis_tdata_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
`default_nettype wire
